// ----- src/b32e_pkg.sv -----
// Shared types, constants and the symbol-to-character function of the base32 encoder.
package b32e_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned SYM_W  = 5;
	localparam int unsigned CHAR_W = 7;

	localparam logic [CHAR_W-1:0] PAD_CHAR = 7'h3D;

	// One work unit passed from the front to the back: up to three symbols,
	// left-aligned in syms (first symbol in the top bits), and the padding to follow.
	typedef struct packed {
		logic [3*SYM_W-1:0] syms;
		logic [1:0]         nsym;
		logic [2:0]         npad;
		logic               last;
	} cmd_t;

	// Standard alphabet: A..Z for 0..25, then 2..7.
	function automatic logic [CHAR_W-1:0] sym_to_char(input logic [SYM_W-1:0] sym);
		logic [CHAR_W-1:0] ch;
		if (sym < 5'd26) begin
			ch = 7'h41 + {2'b00, sym};
		end else begin
			ch = 7'h32 + {2'b00, sym - 5'd26};
		end
		return ch;
	endfunction

endpackage

// ----- src/base32_stream_encoder_unit.sv -----
// Top level of the streaming base32 encoder: front end, work queue and back end.
//
//  channel  | dir | handshake                    | payload
//  ---------+-----+------------------------------+-----------------------------------
//  s_axis   | in  | s_axis_tvalid/s_axis_tready  | tdata[7:0] data byte, tlast = last
//  m_axis   | out | m_axis_tvalid/m_axis_tready  | tdata[6:0] character, tlast = last
//
// Each input word yields one to three data characters and, on the last byte of a
// message, the '=' padding that brings the character count to a multiple of eight.
// The back end emits one character per cycle while m_axis_tready stays high, so a byte
// that does not end a message yields one or two characters, 1.6 on average since
// five bytes make eight characters, and the last byte of a message up to eight.
// The input side keeps accepting while the queue has room,
// and the registered output stage lets a waiting character sit without stopping
// the front end. The asynchronous reset clears the leftover bits, the counters,
// the queue and the output valid; no clearing pass is needed.
module base32_stream_encoder_unit
	import b32e_pkg::*;
#(
	parameter int unsigned FIFO_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
	input  logic       s_axis_tlast,   // in_last
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [6:0] out_char, [7] zero
	output logic       m_axis_tlast    // out_last
);

	cmd_t              front_cmd;
	cmd_t              head_cmd;
	logic              fifo_full;
	logic              fifo_not_empty;
	logic              fifo_pop;
	logic              accept;
	logic [CHAR_W-1:0] out_char;

	// A word is taken whenever the queue has room for its work unit.
	assign s_axis_tready = !fifo_full;
	assign accept        = s_axis_tvalid && s_axis_tready;

	b32e_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.in_byte (s_axis_tdata),
		.in_last (s_axis_tlast),
		.cmd     (front_cmd)
	);

	b32e_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.wr_cmd    (front_cmd),
		.full      (fifo_full),
		.pop       (fifo_pop),
		.not_empty (fifo_not_empty),
		.rd_cmd    (head_cmd)
	);

	b32e_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (fifo_not_empty),
		.head       (head_cmd),
		.pop        (fifo_pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_char   (out_char),
		.out_last   (m_axis_tlast)
	);

	assign m_axis_tdata = {1'b0, out_char};

endmodule

// ----- src/b32e_front.sv -----
// Front end: accepts bytes, splits the bit stream into symbols and plans padding.
module b32e_front
	import b32e_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [BYTE_W-1:0] in_byte,
	input  logic              in_last,
	output cmd_t              cmd
);

	logic [3:0]  lb_q;
	logic [2:0]  lc_q;
	logic [2:0]  cm_q;

	logic [11:0] aligned;
	logic        two_data;
	logic [2:0]  rem;
	logic        flush;
	logic [1:0]  nsym;
	logic [2:0]  cm_after;
	logic [2:0]  pad_raw;
	logic [3:0]  pad_max;
	logic [2:0]  pads;
	logic [3:0]  rem_mask;

	always_comb begin
		// Left-align the valid bits so the first symbol sits in the top five bits.
		aligned  = {lb_q, in_byte} << (3'd4 - lc_q);
		two_data = (lc_q >= 3'd2);
		rem      = two_data ? (lc_q - 3'd2) : (lc_q + 3'd3);
		flush    = in_last && (rem != 3'd0);
		nsym     = 2'd1 + {1'b0, two_data} + {1'b0, flush};
		cm_after = cm_q + {1'b0, nsym};
		pad_raw  = 3'd0 - cm_after;
		pad_max  = 4'd8 - {2'b00, nsym};
		if (!in_last) begin
			pads = 3'd0;
		end else if ({1'b0, pad_raw} > pad_max) begin
			pads = pad_max[2:0];
		end else begin
			pads = pad_raw;
		end
		// With four bits left over the shift clears the mask and the subtraction
		// wraps it to all ones.
		rem_mask = (4'd1 << rem) - 4'd1;
		cmd.syms = {aligned, 3'b000};
		cmd.nsym = nsym;
		cmd.npad = pads;
		cmd.last = in_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lb_q <= '0;
			lc_q <= '0;
			cm_q <= '0;
		end else if (accept) begin
			if (in_last) begin
				lb_q <= '0;
				lc_q <= '0;
				cm_q <= '0;
			end else begin
				lb_q <= in_byte[3:0] & rem_mask;
				lc_q <= rem;
				cm_q <= cm_after;
			end
		end
	end

endmodule

// ----- src/b32e_fifo.sv -----
// Small register queue of work units between the front and the back.
module b32e_fifo
	import b32e_pkg::*;
#(
	parameter int unsigned DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t wr_cmd,
	output logic full,
	input  logic pop,
	output logic not_empty,
	output cmd_t rd_cmd
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == FULL_CNT);
	assign not_empty = (count_q != '0);
	assign rd_cmd    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- src/b32e_back.sv -----
// Back end: expands work units into registered characters, one per cycle unless stalled.
module b32e_back
	import b32e_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  cmd_t              head,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [CHAR_W-1:0] out_char,
	output logic              out_last
);

	logic [2:0]        idx_q;
	logic              valid_q;
	logic [CHAR_W-1:0] char_q;
	logic              last_q;

	logic [3:0]        total;
	logic              is_end;
	logic              load;
	logic [SYM_W-1:0]  sym;
	logic [CHAR_W-1:0] next_char;

	always_comb begin
		total  = {2'b00, head.nsym} + {1'b0, head.npad};
		is_end = ({1'b0, idx_q} == (total - 4'd1));
		load   = head_valid && (!valid_q || out_ready);
		case (idx_q)
			3'd0:    sym = head.syms[14:10];
			3'd1:    sym = head.syms[9:5];
			default: sym = head.syms[4:0];
		endcase
		next_char = (idx_q < {1'b0, head.nsym}) ? sym_to_char(sym) : PAD_CHAR;
		pop       = load && is_end;
	end

	assign out_valid = valid_q;
	assign out_char  = char_q;
	assign out_last  = last_q;

	always_ff @(posedge clk) begin
		if (load) begin
			char_q <= next_char;
			last_q <= head.last && is_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q   <= is_end ? 3'd0 : idx_q + 3'd1;
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the streaming base32 encoder: random stimulus, predictor, scoreboard.
`timescale 1ns / 1ps

module tb_top;
	import b32e_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 64;
	localparam int RANDOM_BYTES_PER_PHASE = 63;
	localparam int N_DIRECTED = 21;

	// Alphabet packed with its first character in the top byte.
	localparam logic [8*32-1:0] B32_ALPHABET = "ABCDEFGHIJKLMNOPQRSTUVWXYZ234567";

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              last;
	} enc_char_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              last;
	} msg_byte_t;

	// Short messages of every length modulo five, so that each amount of padding
	// and the case with no partial character both come up.
	logic [7:0] directed_data [N_DIRECTED] = '{
		8'h00, 8'hFF, 8'hFF, 8'h00, 8'h55, 8'hAA, 8'hFF, 8'h00, 8'hFF, 8'h80, 8'h01,
		8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h01, 8'h02, 8'h04, 8'h08};
	logic       directed_last [N_DIRECTED] = '{
		1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1,
		1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata = 8'h00;
	logic       s_axis_tlast = 1'b0;
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;
	logic       m_axis_tlast;

	msg_byte_t  pending_bytes [$];
	enc_char_t  expected_chars [$];

	// Predictor state: leftover bits, their count and the characters of the
	// current message modulo eight.
	logic [3:0] held_bits = 4'h0;
	int         held_count = 0;
	logic [2:0] chars_in_group = 3'd0;

	int send_idle_pct = 24;
	int recv_idle_pct = 54;
	int hold_left = 0;
	int cycle_count = 0;
	int mismatches = 0;
	int bytes_sent = 0;
	int chars_checked = 0;
	int messages_queued = 0;

	base32_stream_encoder_unit uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #1 clk = ~clk;

	task automatic push_char(input logic [CHAR_W-1:0] ch, inout int n);
		enc_char_t c;
		c.ch = ch;
		c.last = 1'b0;
		expected_chars.push_back(c);
		chars_in_group = chars_in_group + 3'd1;
		n++;
	endtask

	function automatic logic [CHAR_W-1:0] sym_char(input int sym);
		logic [7:0] code;
		code = B32_ALPHABET[8*(31-(sym & 31)) +: 8];
		return code[CHAR_W-1:0];
	endfunction

	// Appends the characters that one accepted byte produces.
	task automatic encode_byte(input logic [7:0] data, input logic is_last);
		int acc;
		int nbits;
		int n;
		enc_char_t tail;
		acc = (int'(held_bits) << 8) | int'(data);
		nbits = held_count + 8;
		n = 0;
		while (nbits >= SYM_W) begin
			nbits -= SYM_W;
			push_char(sym_char(acc >> nbits), n);
		end
		acc &= (1 << nbits) - 1;
		if (!is_last) begin
			held_bits = acc[3:0];
			held_count = nbits;
		end else begin
			// Left-align what remains into one more symbol, then pad the group.
			if (nbits > 0)
				push_char(sym_char(acc << (SYM_W - nbits)), n);
			while (chars_in_group != 3'd0 && n < 8)
				push_char(PAD_CHAR, n);
			if (n > 0) begin
				tail = expected_chars.pop_back();
				tail.last = 1'b1;
				expected_chars.push_back(tail);
			end
			held_bits = 4'h0;
			held_count = 0;
			chars_in_group = 3'd0;
		end
	endtask

	// Input side: predict on every accepted word, then offer the next one.
	always @(posedge clk or negedge arst_n) begin : byte_driver
		msg_byte_t nxt;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= 8'h00;
			s_axis_tlast <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				encode_byte(s_axis_tdata, s_axis_tlast);
				bytes_sent++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = pending_bytes.pop_front();
					s_axis_tdata <= nxt.data;
					s_axis_tlast <= nxt.last;
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Output side: compare each accepted word with the oldest expectation and
	// now and then hold ready low long enough for the input to back up.
	always @(posedge clk or negedge arst_n) begin : char_monitor
		enc_char_t want;
		logic took;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			took = m_axis_tvalid && m_axis_tready;
			if (took) begin
				if (expected_chars.size() == 0) begin
					$error("out_char: none expected, got 0x%02h", m_axis_tdata[6:0]);
					mismatches++;
				end else begin
					want = expected_chars.pop_front();
					if (m_axis_tdata[6:0] !== want.ch) begin
						$error("out_char: expected 0x%02h, got 0x%02h", want.ch, m_axis_tdata[6:0]);
						mismatches++;
					end
					if (m_axis_tlast !== want.last) begin
						$error("out_last: expected %0b, got %0b", want.last, m_axis_tlast);
						mismatches++;
					end
					if (m_axis_tdata[7] !== 1'b0) begin
						$error("tdata[7]: expected 0, got %0b", m_axis_tdata[7]);
						mismatches++;
					end
				end
				chars_checked++;
			end
			if (took && chars_checked % 128 == 100) begin
				hold_left = HOLD_CYCLES;
				m_axis_tready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	initial begin : stimulus
		int phase;
		int queued;
		int len;
		int k;
		int pick;
		msg_byte_t b;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (phase = 0; phase < 3; phase++) begin
			// Sender and receiver swap idle rates, then both run free.
			send_idle_pct = (phase == 0) ? 24 : (phase == 1) ? 54 : 0;
			recv_idle_pct = (phase == 0) ? 54 : (phase == 1) ? 24 : 0;
			if (phase == 0) begin
				for (k = 0; k < N_DIRECTED; k++) begin
					b.data = directed_data[k];
					b.last = directed_last[k];
					pending_bytes.push_back(b);
					if (b.last)
						messages_queued++;
				end
			end
			queued = 0;
			while (queued < RANDOM_BYTES_PER_PHASE) begin
				len = ($urandom_range(3) == 0) ? $urandom_range(20, 9) : $urandom_range(8, 1);
				for (k = 0; k < len; k++) begin
					pick = $urandom_range(9);
					b.data = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom_range(255));
					b.last = (k == len - 1);
					pending_bytes.push_back(b);
				end
				queued += len;
				messages_queued++;
			end
			// The sender pauses here until every character of the phase is back.
			while (pending_bytes.size() != 0 || s_axis_tvalid || expected_chars.size() != 0)
				@(posedge clk);
		end

		repeat (16) @(posedge clk);
		$display("Encoded %0d bytes in %0d messages and checked %0d characters.",
			bytes_sent, messages_queued, chars_checked);
		$display("Ran both idle mixes, a free-running phase and %0d-cycle output stalls.",
			HOLD_CYCLES);
		if (mismatches == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
src/b32e_pkg.sv
src/b32e_front.sv
src/b32e_fifo.sv
src/b32e_back.sv
src/base32_stream_encoder_unit.sv
tb/tb_top.sv
